[hdl/kdp_pkg.sv]
package kdp_pkg;

  localparam int MAX_CAPACITY_DEF = 1023;
  localparam int VALUE_BITS_DEF   = 32;

  // fixed field widths of the ports
  localparam int CAP_W       = 10;
  localparam int IN_VALUE_W  = 16;
  localparam int OUT_VALUE_W = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 10'd1023;

  // status of one table entry update
  typedef struct packed {
    logic write;
    logic sat;
  } kdp_upd_t;

endpackage

[hdl/zero_one_knapsack_dp.sv]
// 0/1 knapsack over an exact-weight table held in a dual-read, single-write
// memory of MAX_CAPACITY+1 entries (reachable bit plus best value). Each item
// sweeps the table from the effective capacity min(capacity, MAX_CAPACITY)
// down to its weight, one entry per cycle, before the next item can be
// taken; an item heavier than the capacity skips the sweep. A last item is
// followed by a scan of the whole table that finds the best value (lowest
// weight on ties) and clears each entry as it passes, before the result is
// loaded into the output register. After reset a clearing pass over the
// whole table runs before the first item is taken; configuration writes are
// taken at any time. The result register lets the next item in while a
// result still waits to be taken.
module zero_one_knapsack_dp #(
  parameter int MAX_CAPACITY = kdp_pkg::MAX_CAPACITY_DEF,
  parameter int VALUE_BITS   = kdp_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kdp_pkg::CAP_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kdp_pkg::CAP_W-1:0]       item_weight,
  input  logic [kdp_pkg::IN_VALUE_W-1:0]  item_value,
  input  logic                            last_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kdp_pkg::OUT_VALUE_W-1:0] best_value,
  output logic [kdp_pkg::CAP_W-1:0]       best_weight,
  output logic                            value_saturated
);

  import kdp_pkg::*;

  localparam int DEPTH = MAX_CAPACITY + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = VALUE_BITS + 1;
  localparam int CW    = (AW > CAP_W) ? AW : CAP_W;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SWEEP    = 3'd2;
  localparam logic [2:0] ST_DRAIN    = 3'd3;
  localparam logic [2:0] ST_SCAN     = 3'd4;
  localparam logic [2:0] ST_SCAN_END = 3'd5;
  localparam logic [2:0] ST_RESULT   = 3'd6;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CAPACITY);

  logic [2:0]            state;
  logic [AW-1:0]         j;
  logic [AW-1:0]         cap_q;
  logic [AW-1:0]         w_q;
  logic [IN_VALUE_W-1:0] v_q;
  logic                  last_q;
  logic [CAP_W-1:0]      capacity;

  logic                  p_valid;
  logic                  p_scan;
  logic [AW-1:0]         p_addr;

  logic                  sat_seen;
  logic                  found;
  logic [VALUE_BITS-1:0] best_v;
  logic [AW-1:0]         best_w;

  logic [CW-1:0]         cap_ext;
  logic [CW-1:0]         max_ext;
  logic [CW-1:0]         eff_ext;
  logic [CW-1:0]         w_ext;
  logic [AW-1:0]         eff_cap;
  logic                  fits;
  logic                  in_acc;
  logic                  out_load;

  logic [AW-1:0]         rd_a_addr;
  logic [AW-1:0]         rd_b_addr;
  logic [DW-1:0]         rd_a_data;
  logic [DW-1:0]         rd_b_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DW-1:0]         wr_data;

  logic [VALUE_BITS-1:0] upd_value;
  kdp_upd_t              upd;

  logic                  scan_hit;
  logic [VALUE_BITS+OUT_VALUE_W-1:0] best_v_ext;
  logic [AW+CAP_W-1:0]               best_w_ext;

  assign cap_ext = CW'(capacity);
  assign max_ext = CW'(MAX_CAPACITY);
  assign eff_ext = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign eff_cap = eff_ext[AW-1:0];
  assign w_ext   = CW'(item_weight);
  assign fits    = (w_ext <= eff_ext);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == ST_RESULT) && (!out_valid || out_ready);

  // dst on port a, src on port b
  assign rd_a_addr = j;
  assign rd_b_addr = j - w_q;

  kdp_table #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk       (clk),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  kdp_update #(
    .VALUE_BITS (VALUE_BITS)
  ) u_update (
    .src_reach  (rd_b_data[DW-1]),
    .src_value  (rd_b_data[VALUE_BITS-1:0]),
    .dst_reach  (rd_a_data[DW-1]),
    .dst_value  (rd_a_data[VALUE_BITS-1:0]),
    .item_value (v_q),
    .new_value  (upd_value),
    .status     (upd)
  );

  // write port: sweep update, scan clear, or reset clearing pass
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j;
    wr_data = {(j == '0), {VALUE_BITS{1'b0}}};
    if (p_valid) begin
      wr_addr = p_addr;
      if (p_scan) begin
        wr_en   = 1'b1;
        wr_data = {(p_addr == '0), {VALUE_BITS{1'b0}}};
      end else begin
        wr_en   = upd.write;
        wr_data = {1'b1, upd_value};
      end
    end else if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end
  end

  assign scan_hit = p_valid && p_scan && (p_addr <= cap_q) && rd_a_data[DW-1]
                    && (!found || (rd_a_data[VALUE_BITS-1:0] > best_v));

  assign best_v_ext = {{OUT_VALUE_W{1'b0}}, best_v};
  assign best_w_ext = {{CAP_W{1'b0}}, best_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      j         <= '0;
      capacity  <= CAPACITY_RESET;
      p_valid   <= 1'b0;
      sat_seen  <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end

      if (p_valid && !p_scan && upd.sat) begin
        sat_seen <= 1'b1;
      end

      if (scan_hit) begin
        found  <= 1'b1;
        best_v <= rd_a_data[VALUE_BITS-1:0];
        best_w <= p_addr;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          if (j == LAST_ADDR) begin
            state <= ST_IDLE;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_IDLE: begin
          found <= 1'b0;
          if (in_acc) begin
            cap_q  <= eff_cap;
            w_q    <= w_ext[AW-1:0];
            v_q    <= item_value;
            last_q <= last_item;
            if (fits) begin
              j     <= eff_cap;
              state <= ST_SWEEP;
            end else if (last_item) begin
              j     <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SWEEP: begin
          p_valid <= 1'b1;
          p_scan  <= 1'b0;
          p_addr  <= j;
          if (j == w_q) begin
            state <= ST_DRAIN;
          end else begin
            j <= j - 1'b1;
          end
        end
        ST_DRAIN: begin
          // last update of the sweep is written here
          p_valid <= 1'b0;
          found   <= 1'b0;
          if (last_q) begin
            j     <= '0;
            state <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          p_valid <= 1'b1;
          p_scan  <= 1'b1;
          p_addr  <= j;
          if (j == LAST_ADDR) begin
            state <= ST_SCAN_END;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_SCAN_END: begin
          p_valid <= 1'b0;
          state   <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            sat_seen <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      best_value      <= best_v_ext[OUT_VALUE_W-1:0];
      best_weight     <= best_w_ext[CAP_W-1:0];
      value_saturated <= sat_seen;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_pending_write: assert property (
    @(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !p_valid
  ) else $error("table write pending while idle");

  a_sweep_above_weight: assert property (
    @(posedge clk) disable iff (rst) (state == ST_SWEEP) |-> (j >= w_q)
  ) else $error("sweep address below item weight");

  a_scan_clears_entry: assert property (
    @(posedge clk) disable iff (rst) (p_valid && p_scan) |-> wr_en
  ) else $error("scan stage did not clear its entry");

  a_result_from_scan: assert property (
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> ($past(state) == ST_RESULT)
  ) else $error("result raised outside of result state");

  a_sat_cleared: assert property (
    @(posedge clk) disable iff (rst) out_load |=> !sat_seen
  ) else $error("saturation flag not cleared after result");
`endif

endmodule

[hdl/kdp_table.sv]
module kdp_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 33
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_a_addr,
  input  logic [AW-1:0] rd_b_addr,
  output logic [DW-1:0] rd_a_data,
  output logic [DW-1:0] rd_b_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

[hdl/kdp_update.sv]
module kdp_update #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          src_reach,
  input  logic [VALUE_BITS-1:0]         src_value,
  input  logic                          dst_reach,
  input  logic [VALUE_BITS-1:0]         dst_value,
  input  logic [kdp_pkg::IN_VALUE_W-1:0] item_value,
  output logic [VALUE_BITS-1:0]         new_value,
  output kdp_pkg::kdp_upd_t             status
);

  import kdp_pkg::*;

  localparam int SUM_W = ((VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W) + 1;

  logic [SUM_W-1:0]      sum;
  logic                  over;
  logic [VALUE_BITS-1:0] cand;

  // anything at or above bit VALUE_BITS means the sum left the value range
  assign sum       = SUM_W'(src_value) + SUM_W'(item_value);
  assign over      = |sum[SUM_W-1:VALUE_BITS];
  assign cand      = over ? '1 : sum[VALUE_BITS-1:0];
  assign new_value = cand;

  assign status.sat   = src_reach && over;
  assign status.write = src_reach && (!dst_reach || (cand > dst_value));

endmodule
